FILE: hdl/nidtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nidtp_pkg
// Types, character codes and limits shared by the node id text parser.
// ----------------------------------------------------------------------------
package nidtp_pkg;

    // parse phase, one-hot
    typedef enum logic [2:0] {
        PH_LEAD  = 3'b001,
        PH_BODY  = 3'b010,
        PH_TRAIL = 3'b100
    } phase_t;

    // number notation selected by the prefix
    typedef enum logic [1:0] {
        NOT_BARE = 2'd0,
        NOT_BANG = 2'd1,
        NOT_0X   = 2'd2
    } notation_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    localparam logic [3:0] MAX_HEX_DIGITS = 4'd8;
    localparam logic [3:0] MAX_DEC_DIGITS = 4'd10;
    localparam logic [3:0] COUNT_SAT      = 4'd15;

    // digit value 0..15, bit 4 set when the character is no hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd16;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = 5'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d = 5'(c - 8'h61 + 8'd10);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d = 5'(c - 8'h41 + 8'd10);
        end
        return d;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

FILE: hdl/nidtp_char_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nidtp_char_if
// Character channel: one text character per transaction.
// ----------------------------------------------------------------------------
interface nidtp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

FILE: hdl/nidtp_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nidtp_result_if
// Result channel: validity flag and parsed node identifier.
// ----------------------------------------------------------------------------
interface nidtp_result_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [31:0] node_id;

    modport source (output valid, output ok, output node_id, input ready);
    modport sink   (input valid, input ok, input node_id, output ready);
endinterface

FILE: hdl/node_id_text_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_id_text_parser
// Parses a node identifier given as text, one character per transaction.
// A zero character ends the text and produces one result transaction.
// ----------------------------------------------------------------------------
//  channel | direction | payload              | transaction
//  text    | sink      | ch[7:0]              | one character, zero ends text
//  ident   | source    | ok, node_id[31:0]    | one per zero character
//
//  one character is taken every cycle while text.ready is high; each updates the parse state in the
//  cycle it is accepted (shift-add by ten and a 36-bit overflow compare)
//  a zero character loads the result register at the edge that accepts it,
//  so the result is offered from the next cycle on
//  the result register decouples the sides: text.ready drops only while a
//  result is held and ident.ready is low
//  reset clears the parse state and empties the result register
// ----------------------------------------------------------------------------
module node_id_text_parser
    import nidtp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    nidtp_char_if.sink            text,
    nidtp_result_if.source        ident
);

    // parse state
    phase_t      phase_reg,   phase_next;
    notation_t   notation_reg, notation_next;
    logic [31:0] hex_reg,     hex_next;
    logic [31:0] dec_reg,     dec_next;
    logic [3:0]  count_reg,   count_next;
    logic        saw_hex_reg, saw_hex_next;
    logic        failed_reg,  failed_next;

    // result register
    logic        res_valid_reg;
    logic        res_ok_reg,  res_ok_next;
    logic [31:0] res_id_reg,  res_id_next;

    logic        accept;
    logic        end_of_text;
    logic        body_char;
    logic        blank;
    logic [4:0]  digit;
    logic [35:0] dec_times_ten;
    logic        as_dec;
    logic        final_ok;

    // a new character is taken whenever the result slot is free or draining
    assign text.ready  = !res_valid_reg || ident.ready;
    assign accept      = text.valid && text.ready;
    assign end_of_text = (text.ch == CH_NUL);

    assign blank = is_blank(text.ch);
    assign digit = hex_digit(text.ch);

    // dec * 10 as two shifted adds, plus the new digit
    assign dec_times_ten = {1'b0, dec_reg, 3'b000} + {3'b000, dec_reg, 1'b0}
                         + {31'd0, digit};

    // final decision on the state before the zero character
    assign as_dec   = (notation_reg == NOT_BARE) && !saw_hex_reg;
    assign final_ok = !failed_reg && (count_reg != 4'd0)
                    && (as_dec ? (count_reg <= MAX_DEC_DIGITS)
                               : (count_reg <= MAX_HEX_DIGITS));
    assign res_ok_next = final_ok;
    assign res_id_next = final_ok ? (as_dec ? dec_reg : hex_reg) : 32'd0;

    // which characters go through the body rules
    always_comb
    begin
        body_char = 1'b0;
        unique case (phase_reg)
            PH_LEAD:
            begin
                body_char = !(text.ch == CH_SPACE || text.ch == CH_TAB)
                         && (text.ch != CH_BANG);
            end
            PH_BODY:  body_char = 1'b1;
            PH_TRAIL: body_char = 1'b0;
            default:  body_char = 1'b0;
        endcase
    end

    // next parse state for a non-zero character
    always_comb
    begin
        phase_next    = phase_reg;
        notation_next = notation_reg;
        hex_next      = hex_reg;
        dec_next      = dec_reg;
        count_next    = count_reg;
        saw_hex_next  = saw_hex_reg;
        failed_next   = failed_reg;

        if (phase_reg == PH_LEAD && !(text.ch == CH_SPACE || text.ch == CH_TAB))
        begin
            phase_next = PH_BODY;
            if (text.ch == CH_BANG)
            begin
                notation_next = NOT_BANG;
            end
        end
        if (phase_reg == PH_TRAIL && !blank)
        begin
            failed_next = 1'b1;
        end

        if (body_char)
        begin
            if (blank)
            begin
                phase_next = PH_TRAIL;
            end
            else if (notation_reg == NOT_BARE && count_reg == 4'd1 && hex_reg == 32'd0
                     && (text.ch == CH_LOW_X || text.ch == CH_UP_X))
            begin
                // a single leading zero followed by x: hex prefix
                notation_next = NOT_0X;
                count_next    = 4'd0;
                hex_next      = 32'd0;
                dec_next      = 32'd0;
            end
            else if (digit[4])
            begin
                failed_next = 1'b1;
            end
            else
            begin
                saw_hex_next = saw_hex_reg || (digit >= 5'd10);
                if (count_reg < COUNT_SAT)
                begin
                    count_next = count_reg + 4'd1;
                end
                hex_next = {hex_reg[27:0], digit[3:0]};
                if (!saw_hex_next && !failed_reg)
                begin
                    if (dec_times_ten[35:32] != 4'd0)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        dec_next = dec_times_ten[31:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LEAD;
            notation_reg <= NOT_BARE;
            hex_reg      <= 32'd0;
            dec_reg      <= 32'd0;
            count_reg    <= 4'd0;
            saw_hex_reg  <= 1'b0;
            failed_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (end_of_text)
            begin
                // state clears after every result
                phase_reg    <= PH_LEAD;
                notation_reg <= NOT_BARE;
                hex_reg      <= 32'd0;
                dec_reg      <= 32'd0;
                count_reg    <= 4'd0;
                saw_hex_reg  <= 1'b0;
                failed_reg   <= 1'b0;
            end
            else
            begin
                phase_reg    <= phase_next;
                notation_reg <= notation_next;
                hex_reg      <= hex_next;
                dec_reg      <= dec_next;
                count_reg    <= count_next;
                saw_hex_reg  <= saw_hex_next;
                failed_reg   <= failed_next;
            end
        end
    end

    // result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept && end_of_text)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (ident.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && end_of_text)
        begin
            res_ok_reg <= res_ok_next;
            res_id_reg <= res_id_next;
        end
    end

    assign ident.valid   = res_valid_reg;
    assign ident.ok      = res_ok_reg;
    assign ident.node_id = res_id_reg;

    // a zero character always yields a pending result
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_text |=> res_valid_reg)
        else $error("zero character did not produce a result");

    // parse state is back at its reset value after the end of text
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_text |=> phase_reg == PH_LEAD && count_reg == 4'd0
                                  && !failed_reg && notation_reg == NOT_BARE)
        else $error("parse state not cleared after result");

    // a failed result never carries a value
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_ok_reg |-> res_id_reg == 32'd0)
        else $error("failed result with nonzero node id");

    // a prefix can only be recorded once the body has started
    a_prefix_phase: assert property (@(posedge clk) disable iff (!rst_n)
        notation_reg != NOT_BARE |-> phase_reg != PH_LEAD)
        else $error("notation set during leading whitespace");

    // a held result is never dropped
    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !ident.ready |=> res_valid_reg && $stable(res_id_reg))
        else $error("pending result lost");

endmodule
